// ===== design/client_session_keepalive_table_defines.svh =====
// assertion shorthands, clocked on clk and quiet during rst
`ifndef CLIENT_SESSION_KEEPALIVE_TABLE_DEFINES_SVH
`define CLIENT_SESSION_KEEPALIVE_TABLE_DEFINES_SVH

// same-cycle implication
`define CSKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cskt_pkg.sv =====
package cskt_pkg;

  typedef enum logic [3:0] {
    K_QUEUED     = 4'd0,
    K_BAD_ID     = 4'd1,
    K_TOO_BIG    = 4'd2,
    K_WRONG_ADDR = 4'd3,
    K_CONNECTED  = 4'd4,
    K_FULL       = 4'd5,
    K_UNKNOWN    = 4'd6,
    K_PING       = 4'd7,
    K_KILLED     = 4'd8,
    K_TICK_DONE  = 4'd9,
    K_LIVE       = 4'd10
  } kind_t;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_LIVE   = 2'd2;

  localparam logic [2:0] REG_KILL_AGE      = 3'd0;
  localparam logic [2:0] REG_PING_INTERVAL = 3'd1;
  localparam logic [2:0] REG_ID_LIMIT      = 3'd2;
  localparam logic [2:0] REG_SIZE_LIMIT    = 3'd3;
  localparam logic [2:0] REG_CONNECT_ID    = 3'd4;

  // write commands from the sequencer to the slot store
  typedef struct packed {
    logic wr_all;    // connect: address, both times, connected flag
    logic wr_recv;
    logic wr_ping;
    logic clr_conn;
  } store_cmd_t;

  // results of the shared age compare
  typedef struct packed {
    logic ge_a;
    logic ge_b;
  } age_flags_t;

endpackage

// ===== design/client_session_keepalive_table.sv =====
// Session table with keepalive timeout. One item at a time: in_stall stays high from the
// cycle after an item is accepted until its last result is loaded into the output register,
// and the next item can be taken once that load has returned the sequencer to idle. A tick
// walks the slots with one table read a cycle unless a result waits on the output register:
// a free slot takes the read state alone, a connected slot also the receive-age check, and
// one whose ping spacing must be checked also the ping check; the done result comes last. A
// live notice takes the live state alone, a received packet a read and an evaluate state,
// and a connect request also the search state for each slot up to the first free one
// (none when full). A step that loads a result waits while the output register is stalled.
`include "client_session_keepalive_table_defines.svh"

module client_session_keepalive_table #(
  parameter int CLIENT_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [31:0]        now_seconds,
  input  logic signed [15:0] client_id,
  input  logic [7:0]         packet_id,
  input  logic [15:0]        packet_size,
  input  logic [47:0]        source_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         kind,
  output logic [3:0]         slot,
  output logic [4:0]         clients_connected,
  output logic               last,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import cskt_pkg::*;

  localparam int SLOT_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int COUNT_W = $clog2(CLIENT_SLOTS + 1);
  localparam logic [SLOT_W-1:0]  LAST_PTR  = SLOT_W'(CLIENT_SLOTS - 1);
  localparam logic [COUNT_W-1:0] SLOTS_CNT = COUNT_W'(CLIENT_SLOTS);
  localparam logic [15:0]        SLOTS_ID  = 16'(CLIENT_SLOTS);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_PKT_RD    = 9'b000000010,
    S_PKT_EVAL  = 9'b000000100,
    S_FIND      = 9'b000001000,
    S_SCAN_RD   = 9'b000010000,
    S_SCAN_RECV = 9'b000100000,
    S_SCAN_PING = 9'b001000000,
    S_DONE      = 9'b010000000,
    S_LIVE      = 9'b100000000
  } state_t;

  // configuration
  logic [15:0] kill_age;
  logic [15:0] ping_interval;
  logic [8:0]  packet_id_limit;
  logic [16:0] packet_size_limit;
  logic [7:0]  connect_packet_id;

  // sequencer
  state_t             state, state_next;
  logic [SLOT_W-1:0]  ptr, ptr_next;
  logic [COUNT_W-1:0] count, count_next;

  // item held while it is worked on
  logic [31:0] item_now;
  logic [7:0]  item_pid;
  logic [15:0] item_size;
  logic [47:0] item_addr;
  logic        item_in_range;
  logic        id_in_range;

  // store and age unit
  store_cmd_t  cmd;
  logic        conn;
  logic [47:0] addr_rd;
  logic [31:0] recv_rd;
  logic [31:0] ping_rd;
  logic [31:0] age_stamp;
  logic [15:0] age_lim_a;
  age_flags_t  age;

  // result
  logic              res_free;
  logic              emit;
  kind_t             emit_kind;
  logic [SLOT_W-1:0] emit_slot;
  logic              emit_last;
  kind_t             res_kind;
  logic [SLOT_W+3:0] slot_ext;
  logic [COUNT_W+4:0] count_ext;

  // packet classification
  kind_t pkt_kind;
  logic  pkt_find;

  always_ff @(posedge clk) begin
    if (rst) begin
      kill_age          <= 16'd10;
      ping_interval     <= 16'd3;
      packet_id_limit   <= 9'd16;
      packet_size_limit <= 17'd1024;
      connect_packet_id <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KILL_AGE:      kill_age          <= cfg_data[15:0];
        REG_PING_INTERVAL: ping_interval     <= cfg_data[15:0];
        REG_ID_LIMIT:      packet_id_limit   <= cfg_data[8:0];
        REG_SIZE_LIMIT:    packet_size_limit <= cfg_data;
        REG_CONNECT_ID:    connect_packet_id <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // negative ids have bit 15 set and fall outside the range
  assign id_in_range = ($unsigned(client_id) < SLOTS_ID);
  assign in_stall    = (state != S_IDLE);
  assign res_free    = !out_valid || !out_stall;

  cskt_slot_store #(
    .CLIENT_SLOTS (CLIENT_SLOTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ptr     (ptr),
    .cmd     (cmd),
    .now     (item_now),
    .addr    (item_addr),
    .conn    (conn),
    .addr_rd (addr_rd),
    .recv_rd (recv_rd),
    .ping_rd (ping_rd)
  );

  // first pass checks the receive age, second pass the ping age
  assign age_stamp = (state == S_SCAN_PING) ? ping_rd : recv_rd;
  assign age_lim_a = (state == S_SCAN_PING) ? ping_interval : kill_age;

  cskt_age_unit u_age (
    .now   (item_now),
    .stamp (age_stamp),
    .lim_a (age_lim_a),
    .lim_b (ping_interval),
    .flags (age)
  );

  always_comb begin
    pkt_find = 1'b0;
    if ({1'b0, item_pid} >= packet_id_limit) begin
      pkt_kind = K_BAD_ID;
    end else if ({1'b0, item_size} >= packet_size_limit) begin
      pkt_kind = K_TOO_BIG;
    end else if (item_in_range) begin
      pkt_kind = (addr_rd == item_addr) ? K_QUEUED : K_WRONG_ADDR;
    end else if (item_pid == connect_packet_id) begin
      pkt_kind = K_FULL;
      pkt_find = (count < SLOTS_CNT);
    end else begin
      pkt_kind = K_UNKNOWN;
    end
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    count_next = count;
    emit       = 1'b0;
    emit_kind  = K_QUEUED;
    emit_slot  = '0;
    emit_last  = 1'b1;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_TICK: begin
              ptr_next   = '0;
              state_next = S_SCAN_RD;
            end
            OP_PACKET: begin
              ptr_next   = id_in_range ? client_id[SLOT_W-1:0] : '0;
              state_next = S_PKT_RD;
            end
            OP_LIVE: begin
              ptr_next   = id_in_range ? client_id[SLOT_W-1:0] : '0;
              state_next = S_LIVE;
            end
            default: ;
          endcase
        end
      end
      S_PKT_RD: begin
        state_next = S_PKT_EVAL;
      end
      S_PKT_EVAL: begin
        if (pkt_find) begin
          ptr_next   = '0;
          state_next = S_FIND;
        end else if (res_free) begin
          emit       = 1'b1;
          emit_kind  = pkt_kind;
          emit_slot  = (pkt_kind == K_QUEUED || pkt_kind == K_WRONG_ADDR) ? ptr : '0;
          state_next = S_IDLE;
        end
      end
      S_FIND: begin
        if (!conn) begin
          if (res_free) begin
            emit        = 1'b1;
            emit_kind   = K_CONNECTED;
            emit_slot   = ptr;
            cmd.wr_all  = 1'b1;
            count_next  = count + COUNT_W'(1);
            state_next  = S_IDLE;
          end
        end else begin
          ptr_next = ptr + SLOT_W'(1);
        end
      end
      S_SCAN_RD: begin
        if (conn) begin
          state_next = S_SCAN_RECV;
        end else if (ptr == LAST_PTR) begin
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + SLOT_W'(1);
        end
      end
      S_SCAN_RECV: begin
        if (age.ge_a) begin
          if (res_free) begin
            emit         = 1'b1;
            emit_kind    = K_KILLED;
            emit_slot    = ptr;
            emit_last    = 1'b0;
            cmd.clr_conn = 1'b1;
            if (count != '0) begin
              count_next = count - COUNT_W'(1);
            end
            if (ptr == LAST_PTR) begin
              state_next = S_DONE;
            end else begin
              ptr_next   = ptr + SLOT_W'(1);
              state_next = S_SCAN_RD;
            end
          end
        end else if (age.ge_b) begin
          state_next = S_SCAN_PING;
        end else if (ptr == LAST_PTR) begin
          state_next = S_DONE;
        end else begin
          ptr_next   = ptr + SLOT_W'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_PING: begin
        if (!age.ge_a || res_free) begin
          if (age.ge_a) begin
            emit        = 1'b1;
            emit_kind   = K_PING;
            emit_slot   = ptr;
            emit_last   = 1'b0;
            cmd.wr_ping = 1'b1;
          end
          if (ptr == LAST_PTR) begin
            state_next = S_DONE;
          end else begin
            ptr_next   = ptr + SLOT_W'(1);
            state_next = S_SCAN_RD;
          end
        end
      end
      S_DONE: begin
        if (res_free) begin
          emit       = 1'b1;
          emit_kind  = K_TICK_DONE;
          state_next = S_IDLE;
        end
      end
      S_LIVE: begin
        if (res_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (item_in_range) begin
            emit_kind   = K_LIVE;
            emit_slot   = ptr;
            cmd.wr_recv = 1'b1;
          end else begin
            emit_kind = K_UNKNOWN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item_now      <= now_seconds;
      item_pid      <= packet_id;
      item_size     <= packet_size;
      item_addr     <= source_address;
      item_in_range <= id_in_range;
    end
  end

  assign slot_ext  = {4'b0, emit_slot};
  assign count_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_kind          <= emit_kind;
      slot              <= slot_ext[3:0];
      clients_connected <= count_ext[4:0];
      last              <= emit_last;
    end
  end

  assign kind = res_kind;

  // a waiting result is never overwritten
  `CSKT_ASSERT_NOW(a_no_overwrite, emit, !out_valid || !out_stall, "result overwritten while stalled")
  // a free slot search starts only with room left in the table
  `CSKT_ASSERT_NOW(a_find_has_room, state == S_FIND, count < SLOTS_CNT, "slot search with full table")
  // the count never passes the table size
  `CSKT_ASSERT_NOW(a_count_bound, out_valid, count <= SLOTS_CNT, "connected count out of range")
  // the final result of an item returns the sequencer to idle
  `CSKT_ASSERT_NEXT(a_last_to_idle, emit && emit_last, state == S_IDLE, "sequencer busy after last result")

endmodule

// ===== design/cskt_age_unit.sv =====
module cskt_age_unit (
  input  logic [31:0]             now,
  input  logic [31:0]             stamp,
  input  logic [15:0]             lim_a,
  input  logic [15:0]             lim_b,
  output cskt_pkg::age_flags_t    flags
);
  import cskt_pkg::*;

  logic [31:0] age;

  // elapsed time wraps modulo 2^32
  assign age        = now - stamp;
  assign flags.ge_a = (age >= {16'b0, lim_a});
  assign flags.ge_b = (age >= {16'b0, lim_b});

endmodule

// ===== design/cskt_slot_store.sv =====
module cskt_slot_store #(
  parameter int CLIENT_SLOTS = 16,
  localparam int SLOT_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [SLOT_W-1:0]       ptr,
  input  cskt_pkg::store_cmd_t    cmd,
  input  logic [31:0]             now,
  input  logic [47:0]             addr,
  output logic                    conn,
  output logic [47:0]             addr_rd,
  output logic [31:0]             recv_rd,
  output logic [31:0]             ping_rd
);
  import cskt_pkg::*;

  logic [CLIENT_SLOTS-1:0] connected;
  logic [CLIENT_SLOTS-1:0] addr_ok;
  logic                    addr_ok_q;

  logic [47:0] addr_mem [CLIENT_SLOTS];
  logic [31:0] recv_mem [CLIENT_SLOTS];
  logic [31:0] ping_mem [CLIENT_SLOTS];
  logic [47:0] addr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      connected <= '0;
      addr_ok   <= '0;
      addr_ok_q <= 1'b0;
    end else begin
      addr_ok_q <= addr_ok[ptr];
      if (cmd.wr_all) begin
        connected[ptr] <= 1'b1;
        addr_ok[ptr]   <= 1'b1;
      end
      if (cmd.clr_conn) begin
        connected[ptr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_all) begin
      addr_mem[ptr] <= addr;
    end
    addr_q <= addr_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_all || cmd.wr_recv) begin
      recv_mem[ptr] <= now;
    end
    recv_rd <= recv_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_all || cmd.wr_ping) begin
      ping_mem[ptr] <= now;
    end
    ping_rd <= ping_mem[ptr];
  end

  assign conn = connected[ptr];
  // an address never written reads as zero
  assign addr_rd = addr_ok_q ? addr_q : '0;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cskt_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST = 3'd7;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [47:0] ADDR_A = 48'hC0A8_0107_1F90;
  localparam logic [47:0] ADDR_B = 48'h0A00_0002_0050;
  localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] now;
    logic [15:0] cid;
    logic [7:0]  pid;
    logic [15:0] psize;
    logic [47:0] addr;
  } session_item_t;

  typedef struct {
    kind_t      kind;
    logic [3:0] slot;
    logic [4:0] count;
    logic       fin;
  } session_result_t;

  // n_typed: -1 take the predictor, 0 no result, 1 the typed result
  typedef struct {
    session_item_t   item;
    int              n_typed;
    session_result_t typed;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [31:0] now_seconds = '0;
  logic signed [15:0] client_id = '0;
  logic [7:0] packet_id = '0;
  logic [15:0] packet_size = '0;
  logic [47:0] source_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] kind;
  logic [3:0] slot;
  logic [4:0] clients_connected;
  logic last;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  client_session_keepalive_table dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the configuration and the session table
  logic [15:0] cfg_timeout = 16'd10;
  logic [15:0] cfg_ping = 16'd3;
  logic [8:0]  cfg_id_limit = 9'd16;
  logic [16:0] cfg_size_limit = 17'd1024;
  logic [7:0]  cfg_connect_id = 8'd0;

  logic        slot_live [SLOTS];
  logic [47:0] slot_addr [SLOTS];
  logic [31:0] slot_heard [SLOTS];
  logic [31:0] slot_pinged [SLOTS];
  int          live_clients = 0;
  logic [31:0] tick_total = '0;

  session_result_t expected_results[$];
  directed_row_t   directed_rows[$];
  int error_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;
  logic [31:0] now_cursor = 32'd200;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_addr[i] = '0;
      slot_heard[i] = '0;
      slot_pinged[i] = '0;
    end
  end

  function automatic void predict_session(input session_item_t it,
                                          output session_result_t res[$]);
    logic [31:0] age;
    logic [31:0] ping_age;
    logic in_range;
    logic placed;
    int i;
    res.delete();
    in_range = it.cid < 16'(SLOTS);
    case (it.op)
      OP_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            age = it.now - slot_heard[i];
            ping_age = it.now - slot_pinged[i];
            if (age >= cfg_timeout) begin
              slot_live[i] = 1'b0;
              if (live_clients > 0) live_clients--;
              res.push_back('{K_KILLED, 4'(i), 5'(live_clients), 1'b0});
            end else if (age >= cfg_ping && ping_age >= cfg_ping) begin
              slot_pinged[i] = it.now;
              res.push_back('{K_PING, 4'(i), 5'(live_clients), 1'b0});
            end
          end
        end
        tick_total++;
        res.push_back('{K_TICK_DONE, 4'd0, 5'(live_clients), 1'b1});
      end
      OP_PACKET: begin
        if (it.pid >= cfg_id_limit) begin
          res.push_back('{K_BAD_ID, 4'd0, 5'(live_clients), 1'b1});
        end else if (it.psize >= cfg_size_limit) begin
          res.push_back('{K_TOO_BIG, 4'd0, 5'(live_clients), 1'b1});
        end else if (in_range) begin
          // stored address is compared even for a free slot
          if (slot_addr[it.cid[3:0]] == it.addr)
            res.push_back('{K_QUEUED, it.cid[3:0], 5'(live_clients), 1'b1});
          else
            res.push_back('{K_WRONG_ADDR, it.cid[3:0], 5'(live_clients), 1'b1});
        end else if (it.pid == cfg_connect_id) begin
          placed = 1'b0;
          if (live_clients < SLOTS) begin
            for (i = 0; i < SLOTS; i++) begin
              if (!placed && !slot_live[i]) begin
                slot_addr[i] = it.addr;
                slot_heard[i] = it.now;
                slot_pinged[i] = it.now;
                slot_live[i] = 1'b1;
                live_clients++;
                placed = 1'b1;
                res.push_back('{K_CONNECTED, 4'(i), 5'(live_clients), 1'b1});
              end
            end
          end
          if (!placed) res.push_back('{K_FULL, 4'd0, 5'(live_clients), 1'b1});
        end else begin
          res.push_back('{K_UNKNOWN, 4'd0, 5'(live_clients), 1'b1});
        end
      end
      OP_LIVE: begin
        if (in_range) begin
          slot_heard[it.cid[3:0]] = it.now;
          res.push_back('{K_LIVE, it.cid[3:0], 5'(live_clients), 1'b1});
        end else begin
          res.push_back('{K_UNKNOWN, 4'd0, 5'(live_clients), 1'b1});
        end
      end
      default: ;
    endcase
  endfunction

  function automatic directed_row_t row(logic [1:0] op_v, logic [31:0] now_v,
                                        logic [15:0] cid_v, logic [7:0] pid_v,
                                        logic [15:0] size_v, logic [47:0] addr_v,
                                        int n_v, kind_t kind_v, logic [3:0] slot_v,
                                        logic [4:0] count_v);
    directed_row_t r;
    r.item.op = op_v;
    r.item.now = now_v;
    r.item.cid = cid_v;
    r.item.pid = pid_v;
    r.item.psize = size_v;
    r.item.addr = addr_v;
    r.n_typed = n_v;
    r.typed.kind = kind_v;
    r.typed.slot = slot_v;
    r.typed.count = count_v;
    r.typed.fin = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic send_item(input session_item_t it, input int typed_n,
                           input session_result_t typed_res);
    session_result_t fresh[$];
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    op <= it.op;
    now_seconds <= it.now;
    client_id <= it.cid;
    packet_id <= it.pid;
    packet_size <= it.psize;
    source_address <= it.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_session(it, fresh);
    if (typed_n < 0) begin
      foreach (fresh[k]) expected_results.push_back(fresh[k]);
    end else if (typed_n > 0) begin
      expected_results.push_back(typed_res);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_KILL_AGE:      cfg_timeout = value[15:0];
      REG_PING_INTERVAL: cfg_ping = value[15:0];
      REG_ID_LIMIT:      cfg_id_limit = value[8:0];
      REG_SIZE_LIMIT:    cfg_size_limit = value;
      REG_CONNECT_ID:    cfg_connect_id = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] timeout_v, input logic [15:0] ping_v,
                           input logic [8:0] id_v, input logic [16:0] size_v,
                           input logic [7:0] conn_v);
    write_reg(REG_KILL_AGE, 17'(timeout_v));
    write_reg(REG_PING_INTERVAL, 17'(ping_v));
    write_reg(REG_ID_LIMIT, 17'(id_v));
    write_reg(REG_SIZE_LIMIT, size_v);
    write_reg(REG_CONNECT_ID, 17'(conn_v));
  endtask

  // wait for every expected item, then let a possible silent item finish
  task automatic settle;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int fill_pct, input int idle_pct,
                           input int stall_pct);
    session_item_t it;
    session_result_t none_typed;
    int pick;
    int size_top;
    logic [15:0] slot_pick;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      pick = $urandom_range(99);
      // time creeps forward, with a rare jump anywhere
      if ($urandom_range(99) < 3) now_cursor = $urandom;
      else now_cursor += $urandom_range(0, 3);
      it.now = now_cursor;
      it.cid = 16'($urandom);
      it.pid = 8'($urandom);
      it.psize = 16'($urandom);
      it.addr = {32'($urandom), 16'($urandom)};
      slot_pick = 16'($urandom_range(0, SLOTS - 1));
      if (pick < 30) begin
        it.op = OP_TICK;
      end else if (pick < 75) begin
        it.op = OP_PACKET;
        if ($urandom_range(99) < fill_pct) begin
          if ($urandom_range(1) == 1) it.cid = 16'($urandom_range(SLOTS, 32767));
          else it.cid[15] = 1'b1;
          it.pid = cfg_connect_id;
        end else if ($urandom_range(99) < 75) begin
          it.cid = slot_pick;
          if ($urandom_range(99) < 70) it.addr = slot_addr[slot_pick[3:0]];
          if (cfg_id_limit != 0) it.pid = 8'($urandom_range(0, int'(cfg_id_limit) - 1));
        end
        if (cfg_size_limit != 0 && $urandom_range(99) < 85) begin
          size_top = (cfg_size_limit > 17'd65536) ? 65536 : int'(cfg_size_limit);
          it.psize = 16'($urandom_range(0, size_top - 1));
        end
      end else if (pick < 95) begin
        it.op = OP_LIVE;
        if ($urandom_range(99) < 85) it.cid = slot_pick;
      end else begin
        it.op = OP_RESERVED;
      end
      send_item(it, -1, none_typed);
    end
    settle();
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    session_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d slot %0d", kind, slot));
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind || slot !== want.slot ||
            clients_connected !== want.count || last !== want.fin)
          report_mismatch($sformatf(
            "kind %0d/%0d slot %0d/%0d clients %0d/%0d last %0d/%0d (got/want)",
            kind, want.kind, slot, want.slot, clients_connected, want.count,
            last, want.fin));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d items outstanding", expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    // reset configuration: timeout 10, ping 3, id limit 16, size limit 1024, connect id 0
    directed_rows.push_back(row(OP_TICK, 32'd0, 16'd0, 8'd0, 16'd0, 48'd0,
                                1, K_TICK_DONE, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd1, 16'd0, 8'd16, 16'd0, 48'd0,
                                1, K_BAD_ID, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd1, 16'h7FFF, 8'd255, 16'hFFFF, ADDR_ONES,
                                1, K_BAD_ID, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd1, 16'd3, 8'd15, 16'd1024, ADDR_A,
                                1, K_TOO_BIG, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd1, 16'd3, 8'd1, 16'hFFFF, ADDR_A,
                                1, K_TOO_BIG, 4'd0, 5'd0));
    // free slots still compare against the cleared address
    directed_rows.push_back(row(OP_PACKET, 32'd2, 16'd0, 8'd1, 16'd1023, 48'd0,
                                1, K_QUEUED, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd2, 16'd15, 8'd0, 16'd0, ADDR_ONES,
                                1, K_WRONG_ADDR, 4'd15, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd2, 16'hFFFF, 8'd2, 16'd0, ADDR_A,
                                1, K_UNKNOWN, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd100, 16'h8000, 8'd0, 16'd0, ADDR_A,
                                1, K_CONNECTED, 4'd0, 5'd1));
    directed_rows.push_back(row(OP_PACKET, 32'd101, 16'd16, 8'd0, 16'd0, ADDR_B,
                                1, K_CONNECTED, 4'd1, 5'd2));
    directed_rows.push_back(row(OP_PACKET, 32'd102, 16'h7FFF, 8'd0, 16'd0, ADDR_ONES,
                                1, K_CONNECTED, 4'd2, 5'd3));
    directed_rows.push_back(row(OP_LIVE, 32'd103, 16'h8000, 8'd0, 16'd0, 48'd0,
                                1, K_UNKNOWN, 4'd0, 5'd3));
    directed_rows.push_back(row(OP_LIVE, 32'd103, 16'd5, 8'd0, 16'd0, 48'd0,
                                1, K_LIVE, 4'd5, 5'd3));
    directed_rows.push_back(row(OP_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                                ADDR_ONES, 0, K_QUEUED, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd103, 16'd0, 8'd7, 16'd100, ADDR_A,
                                1, K_QUEUED, 4'd0, 5'd3));
    directed_rows.push_back(row(OP_PACKET, 32'd103, 16'd1, 8'd7, 16'd100, ADDR_A,
                                1, K_WRONG_ADDR, 4'd1, 5'd3));
    directed_rows.push_back(row(OP_TICK, 32'd104, 16'd0, 8'd0, 16'd0, 48'd0,
                                -1, K_QUEUED, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_LIVE, 32'd105, 16'd2, 8'd0, 16'd0, 48'd0,
                                1, K_LIVE, 4'd2, 5'd3));
    directed_rows.push_back(row(OP_TICK, 32'd106, 16'd0, 8'd0, 16'd0, 48'd0,
                                -1, K_QUEUED, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_TICK, 32'd112, 16'd0, 8'd0, 16'd0, 48'd0,
                                -1, K_QUEUED, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_TICK, 32'hFFFF_FFFF, 16'd0, 8'd0, 16'd0, 48'd0,
                                -1, K_QUEUED, 4'd0, 5'd0));
    directed_rows.push_back(row(OP_PACKET, 32'd5, 16'd16, 8'd0, 16'd0, 48'd0,
                                -1, K_QUEUED, 4'd0, 5'd0));
    // time wrapped below the receive time: age is huge
    directed_rows.push_back(row(OP_TICK, 32'd3, 16'd0, 8'd0, 16'd0, 48'd0,
                                -1, K_QUEUED, 4'd0, 5'd0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].n_typed, directed_rows[r].typed);
    settle();

    configure(16'hFFFF, 16'hFFFF, 9'd256, 17'h10000, 8'd255);
    run_phase(70, 80, 0, 0);

    configure(16'd12, 16'd4, 9'd40, 17'd1500, 8'd9);
    run_phase(55, 35, 50, 0);

    configure(16'd1, 16'd1, 9'd1, 17'd1, 8'd0);
    run_phase(50, 40, 0, 50);

    // zero timeout and interval: every connected slot dies on the next tick
    configure(16'd0, 16'd0, 9'd200, 17'd65535, 8'd199);
    run_phase(50, 40, 18, 18);

    // zero limits reject every packet; spare indexes must change nothing
    configure(16'd300, 16'd2, 9'd0, 17'd0, 8'd3);
    for (int s = REG_SPARE_FIRST; s <= REG_SPARE_LAST; s++)
      write_reg(3'(s), 17'($urandom));
    run_phase(20, 40, 18, 18);

    configure(16'd30, 16'd5, 9'd64, 17'd4096, 8'd17);
    hold_request = 1'b1;
    run_phase(75, 50, 0, 0);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
